// ----- rtl/ttd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types, constants and helpers of the tap and drag gesture detector.
// ----------------------------------------------------------------------------
package ttd_pkg;

    localparam int FINGER_SLOTS = 5;
    localparam int INPUT_PAIRS  = 5;
    localparam int SLOT_W       = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
    localparam int CNT_W        = $clog2(FINGER_SLOTS + 1);
    localparam int POS_W        = 12;
    localparam int TIME_W       = 32;
    localparam int MOVE_W       = 13;
    localparam int GAIN_W       = 16;
    localparam int HOLD_W       = 16;
    localparam int PROD_W       = POS_W + GAIN_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MOVE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIME_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_GAIN      = 2'd2;

    localparam logic [MOVE_W-1:0] TAP_MOVE_RESET = 13'd10;
    localparam logic [HOLD_W-1:0] TAP_TIME_RESET = 16'd200;
    localparam logic [GAIN_W-1:0] MOVE_GAIN_RESET = 16'd256;

    localparam logic EV_MOVE  = 1'b0;
    localparam logic EV_CLICK = 1'b1;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    localparam logic signed [7:0] MOVE_MAX = 8'sd127;

    typedef struct packed {
        logic [2:0]        touch_count;
        logic [TIME_W-1:0] time_ms;
        logic [POS_W-1:0]  pos_x0;
        logic [POS_W-1:0]  pos_y0;
        logic [POS_W-1:0]  pos_x1;
        logic [POS_W-1:0]  pos_y1;
        logic [POS_W-1:0]  pos_x2;
        logic [POS_W-1:0]  pos_y2;
        logic [POS_W-1:0]  pos_x3;
        logic [POS_W-1:0]  pos_y3;
        logic [POS_W-1:0]  pos_x4;
        logic [POS_W-1:0]  pos_y4;
    } in_t;

    typedef struct packed {
        logic              event_kind;
        logic signed [7:0] move_dx;
        logic signed [7:0] move_dy;
        logic [1:0]        click_button;
    } out_t;

    // one finger record as held in the record store
    typedef struct packed {
        logic [POS_W-1:0]  start_x;
        logic [POS_W-1:0]  start_y;
        logic [POS_W-1:0]  last_x;
        logic [POS_W-1:0]  last_y;
        logic [TIME_W-1:0] start_time;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DRAG_RD,
        ST_DRAG_WB,
        ST_DRAG_OUT,
        ST_LIFT,
        ST_CLICK_OUT
    } state_t;

    function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // slots without an input pair read as zero
    function automatic logic [POS_W-1:0] slot_x(input in_t s, input logic [SLOT_W-1:0] slot);
        case (int'(slot))
            0:       slot_x = s.pos_x0;
            1:       slot_x = s.pos_x1;
            2:       slot_x = s.pos_x2;
            3:       slot_x = s.pos_x3;
            4:       slot_x = s.pos_x4;
            default: slot_x = '0;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] slot_y(input in_t s, input logic [SLOT_W-1:0] slot);
        case (int'(slot))
            0:       slot_y = s.pos_y0;
            1:       slot_y = s.pos_y1;
            2:       slot_y = s.pos_y2;
            3:       slot_y = s.pos_y3;
            4:       slot_y = s.pos_y4;
            default: slot_y = '0;
        endcase
    endfunction

endpackage

// ----- rtl/ttd_finger_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_finger_mem
// Finger record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttd_finger_mem (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ttd_pkg::SLOT_W-1:0] wr_addr,
    input  ttd_pkg::rec_t              wr_data,
    input  logic                       rd_en,
    input  logic [ttd_pkg::SLOT_W-1:0] rd_addr,
    output ttd_pkg::rec_t              rd_data
);

    ttd_pkg::rec_t mem [ttd_pkg::FINGER_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/touch_tap_drag_gesture_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_drag_gesture_top
// Tap and drag gesture detector for multi-touch samples.
//
// Input requests (s_valid/s_ready, s_data) carry one touch sample each: the
// finger count, a millisecond timestamp and five coordinate pairs. Result
// requests (m_valid/m_ready, m_data) carry a mouse move or a button click;
// a sample gives at most one result. The registers tap_move_limit,
// tap_time_limit and move_gain are written through cfg_we/cfg_index/cfg_wdata;
// the user is to write them only while the block is idle, which the block
// itself does not enforce. A sample is registered on entry; the sequencer
// then records each newly landed finger and closes that walk, then takes the
// drag path (read, write back and multiply, clamp) or the lift path, which
// walks the finger records through the single read port of the record store
// one slot a cycle. A sample is taken only when idle.
// Finished results sit in an output register; the next sample is accepted
// while a result waits. If the receiver stalls and a new result is ready,
// the sequencer holds until the output register frees.
// Reset returns the registers to their defaults and clears all finger
// state; the record store itself is not cleared, since every read of it is
// guarded by the session peak and the slot 0 active flag.
// ----------------------------------------------------------------------------
module touch_tap_drag_gesture_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ttd_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ttd_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W  = ttd_pkg::CNT_W;
    localparam int SLOT_W = ttd_pkg::SLOT_W;
    localparam int POS_W  = ttd_pkg::POS_W;
    localparam int PROD_W = ttd_pkg::PROD_W;

    ttd_pkg::state_t state_reg, state_next;

    ttd_pkg::in_t sample_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic active0_reg, active0_next;
    logic drag0_reg, drag0_next;
    logic tap_ok_reg, tap_ok_next;
    logic chk_reg, chk_next;

    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic neg_x_reg, neg_y_reg;

    logic          m_valid_reg, m_valid_next;
    ttd_pkg::out_t m_data_reg, m_data_next;

    logic [ttd_pkg::MOVE_W-1:0] tap_move_limit_reg;
    logic [ttd_pkg::HOLD_W-1:0] tap_time_limit_reg;
    logic [ttd_pkg::GAIN_W-1:0] move_gain_reg;

    // record store access
    logic              wr_en, rd_en;
    logic [SLOT_W-1:0] wr_addr, rd_addr;
    ttd_pkg::rec_t     wr_data, rd_data;

    ttd_finger_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic accept;
    logic out_free;
    logic [CNT_W-1:0] in_count;

    assign s_ready  = (state_reg == ttd_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        if (32'(s_data.touch_count) > ttd_pkg::FINGER_SLOTS) begin
            in_count = CNT_W'(ttd_pkg::FINGER_SLOTS);
        end else begin
            in_count = CNT_W'(s_data.touch_count);
        end
    end

    // drag arithmetic on slot 0
    logic [POS_W-1:0] cur_x0, cur_y0;
    logic [POS_W:0]   drag_span;
    logic             moved_x, moved_y;
    logic             drag_now;
    assign cur_x0     = sample_reg.pos_x0;
    assign cur_y0     = sample_reg.pos_y0;
    assign drag_span  = {1'b0, ttd_pkg::absdiff(cur_x0, rd_data.start_x)}
                      + {1'b0, ttd_pkg::absdiff(cur_y0, rd_data.start_y)};
    assign moved_x    = (cur_x0 != rd_data.last_x);
    assign moved_y    = (cur_y0 != rd_data.last_y);
    assign drag_now   = drag0_reg || (drag_span > tap_move_limit_reg);

    // tap check of the record read out last cycle
    logic [POS_W:0]              lift_move;
    logic [ttd_pkg::TIME_W-1:0]  held;
    logic                        slot_pass;
    logic                        tap_now;
    assign lift_move = {1'b0, ttd_pkg::absdiff(rd_data.last_x, rd_data.start_x)}
                     + {1'b0, ttd_pkg::absdiff(rd_data.last_y, rd_data.start_y)};
    assign held      = sample_reg.time_ms - rd_data.start_time;
    assign slot_pass = (lift_move <= tap_move_limit_reg)
                    && (held <= 32'(tap_time_limit_reg));
    assign tap_now   = tap_ok_reg && (!chk_reg || slot_pass);

    // scaled and clamped deltas
    logic [PROD_W-9:0]  mag_x, mag_y;
    logic signed [7:0]  sat_x, sat_y;
    assign mag_x = prod_x_reg[PROD_W-1:8];
    assign mag_y = prod_y_reg[PROD_W-1:8];
    always_comb begin
        sat_x = (mag_x > (PROD_W-8)'(127)) ? ttd_pkg::MOVE_MAX : $signed({1'b0, mag_x[6:0]});
        sat_y = (mag_y > (PROD_W-8)'(127)) ? ttd_pkg::MOVE_MAX : $signed({1'b0, mag_y[6:0]});
        if (neg_x_reg) sat_x = -sat_x;
        if (neg_y_reg) sat_y = -sat_y;
    end

    logic [1:0] button;
    always_comb begin
        case (int'(peak_reg))
            1:       button = ttd_pkg::BTN_LEFT;
            2:       button = ttd_pkg::BTN_RIGHT;
            default: button = ttd_pkg::BTN_MIDDLE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ttd_pkg::ST_IDLE: begin
                if (accept) state_next = ttd_pkg::ST_INIT;
            end
            ttd_pkg::ST_INIT: begin
                if (idx_reg >= count_reg) begin
                    if (int'(count_reg) == 1 && active0_reg) begin
                        state_next = ttd_pkg::ST_DRAG_RD;
                    end else if (prev_reg != '0 && count_reg == '0) begin
                        state_next = ttd_pkg::ST_LIFT;
                    end else begin
                        state_next = ttd_pkg::ST_IDLE;
                    end
                end
            end
            ttd_pkg::ST_DRAG_RD: state_next = ttd_pkg::ST_DRAG_WB;
            ttd_pkg::ST_DRAG_WB: begin
                if (drag_now && (moved_x || moved_y)) begin
                    state_next = ttd_pkg::ST_DRAG_OUT;
                end else begin
                    state_next = ttd_pkg::ST_IDLE;
                end
            end
            ttd_pkg::ST_DRAG_OUT: begin
                if (out_free) state_next = ttd_pkg::ST_IDLE;
            end
            ttd_pkg::ST_LIFT: begin
                if (idx_reg >= peak_reg) begin
                    state_next = tap_now ? ttd_pkg::ST_CLICK_OUT : ttd_pkg::ST_IDLE;
                end
            end
            ttd_pkg::ST_CLICK_OUT: begin
                if (out_free) state_next = ttd_pkg::ST_IDLE;
            end
            default: state_next = ttd_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        peak_next    = peak_reg;
        active0_next = active0_reg;
        drag0_next   = drag0_reg;
        tap_ok_next  = tap_ok_reg;
        chk_next     = chk_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[SLOT_W-1:0];
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[SLOT_W-1:0];
        case (state_reg)
            ttd_pkg::ST_IDLE: begin
                if (accept) begin
                    count_next = in_count;
                    idx_next   = prev_reg;
                end
            end
            ttd_pkg::ST_INIT: begin
                if (idx_reg < count_reg) begin
                    // record the landing of a new finger
                    wr_en              = 1'b1;
                    wr_data.start_x    = ttd_pkg::slot_x(sample_reg, idx_reg[SLOT_W-1:0]);
                    wr_data.start_y    = ttd_pkg::slot_y(sample_reg, idx_reg[SLOT_W-1:0]);
                    wr_data.last_x     = wr_data.start_x;
                    wr_data.last_y     = wr_data.start_y;
                    wr_data.start_time = sample_reg.time_ms;
                    if (idx_reg == '0) begin
                        active0_next = 1'b1;
                        drag0_next   = 1'b0;
                    end
                    if (idx_reg + CNT_W'(1) > peak_reg) peak_next = idx_reg + CNT_W'(1);
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    prev_next   = count_reg;
                    idx_next    = '0;
                    chk_next    = 1'b0;
                    tap_ok_next = 1'b1;
                end
            end
            ttd_pkg::ST_DRAG_RD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ttd_pkg::ST_DRAG_WB: begin
                // write back the new last position of slot 0
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_data.last_x = cur_x0;
                wr_data.last_y = cur_y0;
                drag0_next     = drag_now;
            end
            ttd_pkg::ST_DRAG_OUT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.event_kind    = ttd_pkg::EV_MOVE;
                    m_data_next.move_dx       = sat_x;
                    m_data_next.move_dy       = sat_y;
                    m_data_next.click_button  = ttd_pkg::BTN_LEFT;
                end
            end
            ttd_pkg::ST_LIFT: begin
                tap_ok_next = tap_now;
                if (idx_reg < peak_reg) begin
                    rd_en    = 1'b1;
                    chk_next = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    chk_next = 1'b0;
                    if (!tap_now) begin
                        // drop the session without a click
                        peak_next    = '0;
                        active0_next = 1'b0;
                        drag0_next   = 1'b0;
                    end
                end
            end
            ttd_pkg::ST_CLICK_OUT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.event_kind   = ttd_pkg::EV_CLICK;
                    m_data_next.move_dx      = '0;
                    m_data_next.move_dy      = '0;
                    m_data_next.click_button = button;
                    peak_next                = '0;
                    active0_next             = 1'b0;
                    drag0_next               = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ttd_pkg::ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            prev_reg    <= '0;
            peak_reg    <= '0;
            active0_reg <= 1'b0;
            drag0_reg   <= 1'b0;
            tap_ok_reg  <= 1'b1;
            chk_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            prev_reg    <= prev_next;
            peak_reg    <= peak_next;
            active0_reg <= active0_next;
            drag0_reg   <= drag0_next;
            tap_ok_reg  <= tap_ok_next;
            chk_reg     <= chk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            sample_reg <= s_data;
        end
        if (state_reg == ttd_pkg::ST_DRAG_WB) begin
            prod_x_reg <= PROD_W'(ttd_pkg::absdiff(cur_x0, rd_data.last_x)) * PROD_W'(move_gain_reg);
            prod_y_reg <= PROD_W'(ttd_pkg::absdiff(cur_y0, rd_data.last_y)) * PROD_W'(move_gain_reg);
            neg_x_reg  <= (cur_x0 < rd_data.last_x);
            neg_y_reg  <= (cur_y0 < rd_data.last_y);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_move_limit_reg <= ttd_pkg::TAP_MOVE_RESET;
            tap_time_limit_reg <= ttd_pkg::TAP_TIME_RESET;
            move_gain_reg      <= ttd_pkg::MOVE_GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ttd_pkg::CFG_TAP_MOVE_LIMIT: tap_move_limit_reg <= cfg_wdata[ttd_pkg::MOVE_W-1:0];
                ttd_pkg::CFG_TAP_TIME_LIMIT: tap_time_limit_reg <= cfg_wdata;
                ttd_pkg::CFG_MOVE_GAIN:      move_gain_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/ttd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_port_checks
// Port-level checks of the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module ttd_port_checks (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input ttd_pkg::out_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a click carries no motion
    a_click: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == ttd_pkg::EV_CLICK |->
            m_data.move_dx == 8'sd0 && m_data.move_dy == 8'sd0
            && m_data.click_button != 2'd3)
        else $error("malformed click report");

    // a move stays within the clamp and carries the left button code; a small gain may
    // scale it down to nothing
    a_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == ttd_pkg::EV_MOVE |->
            m_data.move_dx != 8'sh80 && m_data.move_dy != 8'sh80
            && m_data.click_button == ttd_pkg::BTN_LEFT)
        else $error("malformed move report");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind touch_tap_drag_gesture_top ttd_port_checks u_port_checks (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- dv/ttd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_checker
// Watches the sample and report channels of the gesture detector. For each
// accepted sample it tracks the finger records and works out the report that
// sample should give. Reports leaving the block are compared, oldest first,
// field by field, and the failure count is passed up to the testbench top.
// ----------------------------------------------------------------------------
module ttd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  ttd_pkg::in_t                   s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  ttd_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             reports_owed
);
    import ttd_pkg::*;

    logic [MOVE_W-1:0] lim_move;
    logic [HOLD_W-1:0] lim_hold;
    logic [GAIN_W-1:0] gain;

    bit                finger_on [FINGER_SLOTS];
    logic [POS_W-1:0]  org_x     [FINGER_SLOTS];
    logic [POS_W-1:0]  org_y     [FINGER_SLOTS];
    logic [POS_W-1:0]  cur_x     [FINGER_SLOTS];
    logic [POS_W-1:0]  cur_y     [FINGER_SLOTS];
    logic [TIME_W-1:0] land_ms   [FINGER_SLOTS];
    bit                dragging  [FINGER_SLOTS];
    int unsigned       prev_fingers;
    int unsigned       peak_fingers;

    out_t reports_due[$];
    out_t want;
    int   faults;
    int   reports_seen;

    function automatic int span(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Q8.8 scale, truncate toward zero, saturate symmetrically
    function automatic logic signed [7:0] gain_delta(input int d);
        longint scaled;
        scaled = longint'(d < 0 ? -d : d) * longint'(gain) / 256;
        if (d < 0) scaled = -scaled;
        if (scaled > MOVE_MAX) scaled = MOVE_MAX;
        if (scaled < -longint'(MOVE_MAX)) scaled = -longint'(MOVE_MAX);
        return scaled[7:0];
    endfunction

    function automatic void clear_session();
        for (int i = 0; i < FINGER_SLOTS; i++) begin
            finger_on[i] = 1'b0;
            org_x[i]     = '0;
            org_y[i]     = '0;
            cur_x[i]     = '0;
            cur_y[i]     = '0;
            land_ms[i]   = '0;
            dragging[i]  = 1'b0;
        end
        peak_fingers = 0;
    endfunction

    function automatic void track_sample(input in_t smp);
        logic [POS_W-1:0]  xs [INPUT_PAIRS];
        logic [POS_W-1:0]  ys [INPUT_PAIRS];
        int unsigned       fingers;
        int                dx;
        int                dy;
        logic [TIME_W-1:0] held;
        bit                tap;
        out_t              rep;

        xs = '{smp.pos_x0, smp.pos_x1, smp.pos_x2, smp.pos_x3, smp.pos_x4};
        ys = '{smp.pos_y0, smp.pos_y1, smp.pos_y2, smp.pos_y3, smp.pos_y4};
        fingers = (smp.touch_count > FINGER_SLOTS) ? FINGER_SLOTS : smp.touch_count;

        // record fingers that landed since the last sample
        for (int i = prev_fingers; i < fingers; i++) begin
            finger_on[i] = 1'b1;
            org_x[i]     = (i < INPUT_PAIRS) ? xs[i] : '0;
            org_y[i]     = (i < INPUT_PAIRS) ? ys[i] : '0;
            cur_x[i]     = org_x[i];
            cur_y[i]     = org_y[i];
            land_ms[i]   = smp.time_ms;
            dragging[i]  = 1'b0;
            if (i + 1 > peak_fingers) peak_fingers = i + 1;
        end

        if (fingers == 1 && finger_on[0]) begin
            dx = int'(xs[0]) - int'(cur_x[0]);
            dy = int'(ys[0]) - int'(cur_y[0]);
            if (span(xs[0], org_x[0]) + span(ys[0], org_y[0]) > int'(lim_move)) begin
                dragging[0] = 1'b1;
            end
            if (dragging[0] && (dx != 0 || dy != 0)) begin
                rep            = '0;
                rep.event_kind = EV_MOVE;
                rep.move_dx    = gain_delta(dx);
                rep.move_dy    = gain_delta(dy);
                reports_due.push_back(rep);
            end
            cur_x[0] = xs[0];
            cur_y[0] = ys[0];
        end

        if (prev_fingers > 0 && fingers == 0) begin
            tap = 1'b1;
            for (int i = 0; i < peak_fingers && i < FINGER_SLOTS; i++) begin
                held = smp.time_ms - land_ms[i];
                if (span(cur_x[i], org_x[i]) + span(cur_y[i], org_y[i]) > int'(lim_move)
                        || held > TIME_W'(lim_hold)) begin
                    tap = 1'b0;
                end
            end
            if (tap) begin
                rep              = '0;
                rep.event_kind   = EV_CLICK;
                rep.click_button = (peak_fingers == 1) ? BTN_LEFT :
                                   (peak_fingers == 2) ? BTN_RIGHT : BTN_MIDDLE;
                reports_due.push_back(rep);
            end
            clear_session();
        end

        prev_fingers = fingers;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lim_move     = TAP_MOVE_RESET;
            lim_hold     = TAP_TIME_RESET;
            gain         = MOVE_GAIN_RESET;
            prev_fingers = 0;
            faults       = 0;
            reports_seen = 0;
            clear_session();
            reports_due.delete();
        end else begin
            // compare before predicting: a report never belongs to a sample
            // accepted at the same edge
            if (m_valid && m_ready) begin
                reports_seen++;
                if (reports_due.size() == 0) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("report %0d with none owed: kind %0d dx %0d dy %0d button %0d",
                                 reports_seen, m_data.event_kind, m_data.move_dx,
                                 m_data.move_dy, m_data.click_button);
                    end
                end else begin
                    want = reports_due.pop_front();
                    if (m_data.event_kind !== want.event_kind
                            || m_data.move_dx !== want.move_dx
                            || m_data.move_dy !== want.move_dy
                            || m_data.click_button !== want.click_button) begin
                        faults++;
                        if (faults <= 10) begin
                            $display("report %0d: expected kind %0d dx %0d dy %0d button %0d, got kind %0d dx %0d dy %0d button %0d",
                                     reports_seen, want.event_kind, want.move_dx,
                                     want.move_dy, want.click_button, m_data.event_kind,
                                     m_data.move_dx, m_data.move_dy, m_data.click_button);
                        end
                    end
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_TAP_MOVE_LIMIT: lim_move = cfg_wdata[MOVE_W-1:0];
                    CFG_TAP_TIME_LIMIT: lim_hold = cfg_wdata[HOLD_W-1:0];
                    CFG_MOVE_GAIN:      gain     = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) track_sample(s_data);
        end
        fail_count   <= faults;
        reports_owed <= reports_due.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives touch samples into the tap and drag gesture detector: a directed
// opening of taps, drags and edge cases, then random gestures under several
// register settings with random idling on both channels. A checker beside
// the block predicts and compares the reports; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ttd_pkg::*;

    localparam int RUN_LIMIT    = 300000;
    localparam int SETTLE       = 32;
    localparam int LONG_HOLD    = 400;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 240;
    localparam int OPENING      = 25;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAP_MOVE_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int reports_owed;
    int cycle_count  = 0;
    int samples_sent = 0;
    int hold_asked   = 0;
    int hold_done    = 0;
    bit calm         = 1'b0;
    bit gappy        = 1'b0;
    bit choppy       = 1'b1;

    logic [POS_W-1:0]  fx [INPUT_PAIRS];
    logic [POS_W-1:0]  fy [INPUT_PAIRS];
    logic [TIME_W-1:0] now_ms = '0;

    touch_tap_drag_gesture_top u_dut (.*);
    ttd_checker u_checker (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("touch_tap_drag_gesture_top: mismatch");
            $finish;
        end
    end

    // result side: short random stalls, and a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_done != hold_asked) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_done++;
            end else if (!calm && choppy && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
            if ($urandom_range(0, 47) == 0) choppy = !choppy;
        end
    end

    function automatic logic [POS_W-1:0] nudge(input logic [POS_W-1:0] p, input int reach);
        int v;
        v = int'(p) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0) v = 0;
        if (v > POS_MAX) v = POS_MAX;
        return POS_W'(v);
    endfunction

    function automatic void scatter();
        for (int i = 0; i < INPUT_PAIRS; i++) begin
            fx[i] = POS_W'($urandom);
            fy[i] = POS_W'($urandom);
        end
    endfunction

    function automatic void place(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        for (int i = 0; i < INPUT_PAIRS; i++) begin
            fx[i] = x;
            fy[i] = y;
        end
    endfunction

    // advance the sample clock: mostly short steps, now and then long holds
    // or a jump to just short of the wrap
    function automatic void tick();
        case ($urandom_range(0, 39))
            0:       now_ms = 32'hFFFF_FF80 + $urandom_range(0, 127);
            1, 2:    now_ms = now_ms + $urandom_range(300, 70000);
            default: now_ms = now_ms + (($urandom_range(0, 1) == 1) ?
                                        $urandom_range(0, 3) : $urandom_range(4, 90));
        endcase
    endfunction

    task automatic offer(input logic [2:0] cnt);
        in_t smp;
        smp.touch_count = cnt;
        smp.time_ms     = now_ms;
        smp.pos_x0      = fx[0];
        smp.pos_y0      = fy[0];
        smp.pos_x1      = fx[1];
        smp.pos_y1      = fy[1];
        smp.pos_x2      = fx[2];
        smp.pos_y2      = fy[2];
        smp.pos_x3      = fx[3];
        smp.pos_y3      = fy[3];
        smp.pos_x4      = fx[4];
        smp.pos_y4      = fy[4];
        @(negedge aclk);
        if (!calm && gappy && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    // drop valid and hold until every owed report is out, then let the
    // block finish any sample that gives no report
    task automatic settle_down();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reports_owed != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] mv,
                                 input logic [CFG_DATA_W-1:0] hd,
                                 input logic [CFG_DATA_W-1:0] gn);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAP_MOVE_LIMIT;
        cfg_wdata <= mv;
        @(negedge aclk);
        cfg_index <= CFG_TAP_TIME_LIMIT;
        cfg_wdata <= hd;
        @(negedge aclk);
        cfg_index <= CFG_MOVE_GAIN;
        cfg_wdata <= gn;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic tap_gesture();
        int          peak;
        logic [2:0]  cnt;
        peak = $urandom_range(1, FINGER_SLOTS);
        scatter();
        if ($urandom_range(0, 1) == 1) begin
            for (int k = 1; k <= peak; k++) begin
                tick();
                offer(3'(k));
            end
            cnt = 3'(peak);
        end else begin
            cnt = (peak == FINGER_SLOTS) ? 3'($urandom_range(FINGER_SLOTS, 7)) : 3'(peak);
            tick();
            offer(cnt);
        end
        repeat ($urandom_range(0, 3)) begin
            for (int i = 0; i < INPUT_PAIRS; i++) begin
                fx[i] = nudge(fx[i], 3);
                fy[i] = nudge(fy[i], 3);
            end
            tick();
            offer(cnt);
        end
        tick();
        offer(3'd0);
    endtask

    task automatic drag_gesture(input int steps);
        int reach;
        scatter();
        tick();
        offer(3'd1);
        repeat (steps) begin
            case ($urandom_range(0, 9))
                0:          reach = 0;
                1, 2, 3:    reach = 3;
                4, 5, 6, 7: reach = 60;
                default:    reach = 1500;
            endcase
            fx[0] = nudge(fx[0], reach);
            fy[0] = nudge(fy[0], reach);
            tick();
            // now and then a second finger brushes the pad mid-drag
            offer(($urandom_range(0, 9) == 0) ? 3'd2 : 3'd1);
        end
        tick();
        offer(3'd0);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4)) begin
            scatter();
            if ($urandom_range(0, 3) == 0) now_ms = $urandom;
            else tick();
            offer(3'($urandom_range(0, 7)));
        end
    endtask

    task automatic play_gesture();
        gappy = ($urandom_range(0, 1) == 1);
        case ($urandom_range(0, 19))
            0, 1, 2:                        noise_burst();
            3, 4, 5, 6, 7, 8, 9, 10, 11:    tap_gesture();
            default:                        drag_gesture($urandom_range(2, 14));
        endcase
    endtask

    initial begin
        place('0, '0);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // opening: taps of each button, limits, drags, saturation, wrap
        gappy = 1'b1;
        now_ms = 32'd0;     offer(3'd0);
        now_ms = 32'd1000;  offer(3'd1);
        now_ms = 32'd1100;  offer(3'd0);
        place(POS_W'(POS_MAX), POS_W'(POS_MAX));
        now_ms = 32'd2000;  offer(3'd2);
        now_ms = 32'd2200;  offer(3'd0);
        scatter();
        now_ms = 32'd3000;  offer(3'd7);
        now_ms = 32'd3201;  offer(3'd0);
        now_ms = 32'd4000;  offer(3'd5);
        now_ms = 32'd4010;  offer(3'd0);
        for (int k = 1; k <= 4; k++) begin
            now_ms = 32'd5000 + k;
            offer(3'(k));
        end
        now_ms = 32'd5010;  offer(3'd0);
        place('0, '0);
        now_ms = 32'd6000;  offer(3'd1);
        place(POS_W'(POS_MAX), POS_W'(POS_MAX));
        now_ms = 32'd6010;  offer(3'd1);
        place('0, '0);
        now_ms = 32'd6020;  offer(3'd1);
        now_ms = 32'd6030;  offer(3'd1);
        now_ms = 32'd6040;  offer(3'd0);
        place(12'd100, 12'd100);
        now_ms = 32'd7000;  offer(3'd1);
        fx[0] = 12'd105;
        fy[0] = 12'd105;
        now_ms = 32'd7001;  offer(3'd1);
        fx[0] = 12'd106;
        now_ms = 32'd7002;  offer(3'd1);
        now_ms = 32'd7003;  offer(3'd0);
        place(12'd2048, 12'd2048);
        now_ms = 32'hFFFF_FFF0;  offer(3'd1);
        now_ms = 32'h0000_0010;  offer(3'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_down();
            case (ph)
                0:       apply_setting(16'd0, 16'd0, 16'd0);
                1:       apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2:       apply_setting(16'd25, 16'd120, 16'd384);
                3:       apply_setting(16'd5, 16'd300, 16'd64);
                4:       apply_setting(16'd60, 16'd80, 16'd1024);
                5:       apply_setting({3'($urandom), 13'($urandom_range(0, 40))},
                                       16'($urandom_range(30, 400)), 16'($urandom));
                default: apply_setting(16'd12, 16'd250, 16'd256);
            endcase
            if (ph == PHASES - 1) calm = 1'b1;
            if (ph == 2) begin
                // hold the result side off while a long drag keeps coming
                hold_asked++;
                drag_gesture(40);
            end
            if (ph == 3) begin
                repeat (10) tap_gesture();
                settle_down();
            end
            while (samples_sent < OPENING + (ph + 1) * PHASE_ITEMS) play_gesture();
        end

        settle_down();
        if (fail_count == 0 && reports_owed == 0) begin
            $display("touch_tap_drag_gesture_top: match");
        end else begin
            $display("touch_tap_drag_gesture_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ttd_pkg.sv
rtl/ttd_finger_mem.sv
rtl/touch_tap_drag_gesture_top.sv
rtl/ttd_checker.sv
dv/ttd_checker.sv
dv/testbench.sv
